// File: src/fpwt_pkg.sv
// Shared constants for the fixed-priority schedulability checker.
// Used by fixed_priority_workload_test_top and the testbench; depends on nothing.
`default_nettype none
package fpwt_pkg;
   localparam int MAX_TASKS   = 32;
   localparam int TIME_BITS   = 16;
   localparam int IDX_BITS    = $clog2(MAX_TASKS);
   localparam int CNT_BITS    = $clog2(MAX_TASKS + 1);
   localparam int ACC_BITS    = 2 * TIME_BITS + 2;
   localparam int DSTEP_BITS  = $clog2(TIME_BITS);
   localparam int ENTRY_BITS  = 2 * TIME_BITS;

   typedef logic [TIME_BITS-1:0] time_type;
endpackage
`default_nettype wire

// File: src/fpwt_ram.sv
// Generic single-port-write, registered-read RAM.
// Standalone; holds the stored task parameters.
`default_nettype none
module fpwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: src/fixed_priority_workload_test_top.sv
// Exact fixed-priority schedulability test by scheduling points.
// Each point sums, per stored task, jobs times WCET, the job count coming from the
// shared bit-serial divider; a failing point moves on to the next multiple of a
// stored period below the deadline. Worst case is 32 tasks of period 1, deadline
// 65535.
// Throughput: one request at a time; ready returns with the response. Sync reset empties set.
`default_nettype none
module fixed_priority_workload_test_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_exec_time,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_task_period,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_task_deadline,
   input  wire logic                           req_new_set,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [5:0]                     rsp_task_index,
   output logic                                rsp_task_ok,
   output logic                                rsp_set_ok,
   output logic                                rsp_store_full
);
   localparam int TB = fpwt_pkg::TIME_BITS;
   localparam int CB = fpwt_pkg::CNT_BITS;
   localparam int IB = fpwt_pkg::IDX_BITS;
   localparam int AB = fpwt_pkg::ACC_BITS;
   localparam int DB = fpwt_pkg::DSTEP_BITS;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PT_START  = 4'd1;
   localparam logic [3:0] S_TERM_CHK  = 4'd2;
   localparam logic [3:0] S_TERM_WAIT = 4'd3;
   localparam logic [3:0] S_TERM_LOAD = 4'd4;
   localparam logic [3:0] S_DIV       = 4'd5;
   localparam logic [3:0] S_MUL       = 4'd6;
   localparam logic [3:0] S_ACC       = 4'd7;
   localparam logic [3:0] S_PT_FAIL   = 4'd8;
   localparam logic [3:0] S_GEN_CHK   = 4'd9;
   localparam logic [3:0] S_GEN_WAIT  = 4'd10;
   localparam logic [3:0] S_GEN_LOAD  = 4'd11;
   localparam logic [3:0] S_GEN_MCHK  = 4'd12;
   localparam logic [3:0] S_DONE      = 4'd13;

   logic [3:0]    state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic          set_ok_ff, set_ok_in;
   logic          ok_ff, ok_in;
   logic          in_gen_ff, in_gen_in;
   fpwt_pkg::time_type exec_ff, exec_in, dl_ff, dl_in, per_ff, per_in;
   fpwt_pkg::time_type t_ff, t_in, gp_ff, gp_in, c_ff, c_in, dp_ff, dp_in;
   fpwt_pkg::time_type num_ff, num_in, rem_ff, rem_in, q_ff, q_in;
   logic [TB:0]   m_ff, m_in;
   logic [CB-1:0] gj_ff, gj_in, k_ff, k_in;
   logic [IB-1:0] addr_ff, addr_in;
   logic [DB-1:0] dcnt_ff, dcnt_in;
   logic [2*TB-1:0] prod_ff, prod_in;
   logic [AB-1:0] acc_ff, acc_in, acc_sum;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    rsp_index_ff, rsp_index_in;
   logic          rsp_ok_ff, rsp_ok_in, rsp_set_ff, rsp_set_in, rsp_full_ff, rsp_full_in;

   logic [fpwt_pkg::ENTRY_BITS-1:0] rd_data;
   fpwt_pkg::time_type rd_wcet, rd_per_eff, jobs;
   logic [TB:0]   rem_sh;
   logic          div_ge, full, wr_en, out_free;

   fpwt_ram #(.WIDTH(fpwt_pkg::ENTRY_BITS), .DEPTH(fpwt_pkg::MAX_TASKS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IB-1:0]),
      .wr_data ({exec_ff, per_ff}),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_wcet    = rd_data[2*TB-1:TB];
   // a zero period counts as one tick
   assign rd_per_eff = (rd_data[TB-1:0] == '0) ? TB'(1) : rd_data[TB-1:0];
   assign rem_sh     = {rem_ff, num_ff[TB-1]};
   assign div_ge     = rem_sh >= {1'b0, dp_ff};
   assign jobs       = q_ff + {{(TB-1){1'b0}}, (rem_ff != '0)};
   assign acc_sum    = acc_ff + AB'(prod_ff);
   assign full       = (count_ff == CB'(fpwt_pkg::MAX_TASKS));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign wr_en      = (state_ff == S_DONE) && out_free && !full;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;  count_in = count_ff;  set_ok_in = set_ok_ff;
      ok_in = ok_ff;  in_gen_in = in_gen_ff;  exec_in = exec_ff;  dl_in = dl_ff;
      per_in = per_ff;  t_in = t_ff;  gp_in = gp_ff;  c_in = c_ff;  dp_in = dp_ff;
      num_in = num_ff;  rem_in = rem_ff;  q_in = q_ff;  m_in = m_ff;  gj_in = gj_ff;
      k_in = k_ff;  addr_in = addr_ff;  dcnt_in = dcnt_ff;  prod_in = prod_ff;
      acc_in = acc_ff;  rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;  rsp_ok_in = rsp_ok_ff;  rsp_set_in = rsp_set_ff;
      rsp_full_in = rsp_full_ff;
      prod_in = prod_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               exec_in   = req_exec_time;
               per_in    = req_task_period;
               dl_in     = req_task_deadline;
               t_in      = req_task_deadline;
               in_gen_in = 1'b0;
               if (req_new_set) begin
                  count_in  = '0;
                  set_ok_in = 1'b1;
               end
               state_in = S_PT_START;
            end
         end
         S_PT_START: begin
            acc_in = AB'(exec_ff);
            k_in   = '0;
            state_in = (exec_ff > t_ff) ? S_PT_FAIL : S_TERM_CHK;
         end
         S_TERM_CHK: begin
            if (k_ff == count_ff) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               addr_in  = k_ff[IB-1:0];
               state_in = S_TERM_WAIT;
            end
         end
         S_TERM_WAIT: state_in = S_TERM_LOAD;
         S_TERM_LOAD: begin
            c_in    = rd_wcet;
            dp_in   = rd_per_eff;
            num_in  = t_ff;
            rem_in  = '0;
            q_in    = '0;
            dcnt_in = DB'(TB - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // one restoring step a cycle
            rem_in = div_ge ? TB'(rem_sh - {1'b0, dp_ff}) : TB'(rem_sh);
            q_in   = {q_ff[TB-2:0], div_ge};
            num_in = {num_ff[TB-2:0], 1'b0};
            dcnt_in = dcnt_ff - DB'(1);
            if (dcnt_ff == '0) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = {{TB{1'b0}}, jobs} * {{TB{1'b0}}, c_ff};
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_sum;
            k_in   = k_ff + CB'(1);
            state_in = (acc_sum > AB'(t_ff)) ? S_PT_FAIL : S_TERM_CHK;
         end
         S_PT_FAIL: begin
            if (!in_gen_ff) begin
               in_gen_in = 1'b1;
               gj_in     = '0;
               state_in  = S_GEN_CHK;
            end else begin
               m_in     = m_ff + {1'b0, gp_ff};
               state_in = S_GEN_MCHK;
            end
         end
         S_GEN_CHK: begin
            if (gj_ff == count_ff) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else begin
               addr_in  = gj_ff[IB-1:0];
               state_in = S_GEN_WAIT;
            end
         end
         S_GEN_WAIT: state_in = S_GEN_LOAD;
         S_GEN_LOAD: begin
            gp_in    = rd_per_eff;
            m_in     = {1'b0, rd_per_eff};
            state_in = S_GEN_MCHK;
         end
         S_GEN_MCHK: begin
            if (m_ff < {1'b0, dl_ff}) begin
               t_in     = m_ff[TB-1:0];
               state_in = S_PT_START;
            end else begin
               gj_in    = gj_ff + CB'(1);
               state_in = S_GEN_CHK;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = 6'(count_ff);
               rsp_ok_in    = ok_ff;
               rsp_set_in   = set_ok_ff && ok_ff;
               rsp_full_in  = full;
               set_ok_in    = set_ok_ff && ok_ff;
               if (!full) begin
                  count_in = count_ff + CB'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         set_ok_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         set_ok_ff    <= set_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff <= ok_in;  in_gen_ff <= in_gen_in;  exec_ff <= exec_in;  dl_ff <= dl_in;
      per_ff <= per_in;  t_ff <= t_in;  gp_ff <= gp_in;  c_ff <= c_in;  dp_ff <= dp_in;
      num_ff <= num_in;  rem_ff <= rem_in;  q_ff <= q_in;  m_ff <= m_in;
      gj_ff <= gj_in;  k_ff <= k_in;  addr_ff <= addr_in;  dcnt_ff <= dcnt_in;
      prod_ff <= prod_in;  acc_ff <= acc_in;
      rsp_index_ff <= rsp_index_in;  rsp_ok_ff <= rsp_ok_in;
      rsp_set_ff <= rsp_set_in;  rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_task_index = rsp_index_ff;
   assign rsp_task_ok    = rsp_ok_ff;
   assign rsp_set_ok     = rsp_set_ff;
   assign rsp_store_full = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(fpwt_pkg::MAX_TASKS))
      else $error("task count beyond store depth");
   a_reset_idle: assert property (@(posedge clock) reset |=> state_ff == S_IDLE)
      else $error("sequencer not idle after reset");
   a_write_only_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("store written without a result");
   a_failed_set_sticks: assert property (@(posedge clock) disable iff (reset)
      (!set_ok_ff && state_ff != S_IDLE) |=> !set_ok_ff)
      else $error("set verdict recovered within a set");
endmodule
`default_nettype wire

// File: dv/fpwt_checker.sv
// Scoreboard for fixed_priority_workload_test_top: predicts each verdict from
// the requests it sees and compares the responses. Depends on fpwt_pkg.
`timescale 1ns / 100ps
module fpwt_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_exec_time,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_task_period,
   input  wire logic [fpwt_pkg::TIME_BITS-1:0] req_task_deadline,
   input  wire logic                           req_new_set,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [5:0]                     rsp_task_index,
   input  wire logic                           rsp_task_ok,
   input  wire logic                           rsp_set_ok,
   input  wire logic                           rsp_store_full,
   output int                                  fail_count,
   output int                                  verdicts_pending
);
   typedef struct packed {
      logic [5:0] task_index;
      logic       task_ok;
      logic       set_ok;
      logic       store_full;
   } verdict_type;

   fpwt_pkg::time_type wcet_tbl   [fpwt_pkg::MAX_TASKS];
   fpwt_pkg::time_type period_tbl [fpwt_pkg::MAX_TASKS];
   int          stored_tasks;
   bit          set_good;
   verdict_type verdict_q[$];

   assign verdicts_pending = verdict_q.size();

   // demand of the new task plus all stored tasks at instant t fits within t
   function automatic bit demand_fits(longint exec_t, longint t);
      longint acc;
      longint per;
      acc = exec_t;
      if (acc > t) return 0;
      for (int j = 0; j < stored_tasks; j++) begin
         per = (period_tbl[j] == 0) ? 1 : period_tbl[j];
         acc += ((t + per - 1) / per) * wcet_tbl[j];
         if (acc > t) return 0;
      end
      return 1;
   endfunction

   function automatic bit meets_deadline(longint exec_t, longint dl);
      longint per;
      if (demand_fits(exec_t, dl)) return 1;
      for (int j = 0; j < stored_tasks; j++) begin
         per = (period_tbl[j] == 0) ? 1 : period_tbl[j];
         for (longint m = per; m < dl; m += per)
            if (demand_fits(exec_t, m)) return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      verdict_type v;
      verdict_type got;
      if (reset) begin
         stored_tasks = 0;
         set_good     = 1;
         fail_count   <= 0;
         verdict_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_new_set) begin
               stored_tasks = 0;
               set_good     = 1;
            end
            v.task_index = stored_tasks[5:0];
            v.task_ok    = meets_deadline(req_exec_time, req_task_deadline);
            if (!v.task_ok) set_good = 0;
            v.set_ok     = set_good;
            v.store_full = stored_tasks >= fpwt_pkg::MAX_TASKS;
            if (!v.store_full) begin
               wcet_tbl[stored_tasks]   = req_exec_time;
               period_tbl[stored_tasks] = req_task_period;
               stored_tasks++;
            end
            verdict_q.push_back(v);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_task_index, rsp_task_ok, rsp_set_ok, rsp_store_full};
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               v = verdict_q.pop_front();
               if (got !== v) begin
                  $display("%0t: idx/ok/set/full expected %0d/%b/%b/%b actual %0d/%b/%b/%b",
                           $time, v.task_index, v.task_ok, v.set_ok, v.store_full,
                           rsp_task_index, rsp_task_ok, rsp_set_ok, rsp_store_full);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: dv/tb_fixed_priority_workload_test_top.sv
// Testbench top: clock, reset, request stimulus and final verdict for
// fixed_priority_workload_test_top. Depends on fpwt_pkg and fpwt_checker.
`timescale 1ns / 100ps
module tb_fixed_priority_workload_test_top;
   localparam int CYCLE_LIMIT = 4000000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   fpwt_pkg::time_type req_exec_time = 0;
   fpwt_pkg::time_type req_task_period = 1;
   fpwt_pkg::time_type req_task_deadline = 1;
   logic       req_new_set = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [5:0] rsp_task_index;
   logic       rsp_task_ok;
   logic       rsp_set_ok;
   logic       rsp_store_full;
   int         fail_count;
   int         verdicts_pending;
   int         cycles = 0;
   bit         calm = 0;
   int         stall_left = 0;

   always #10 clock = ~clock;

   fixed_priority_workload_test_top i_dut (.*);

   fpwt_checker i_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fixed_priority_workload_test_top: mismatch");
         $finish;
      end
   end

   // random bursts of response back-pressure
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(1, 4);
         rsp_ready  <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   task automatic send_task(input int e, input int p, input int d, input bit fresh);
      int gap;
      if (!calm && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1;
      req_exec_time     <= fpwt_pkg::TIME_BITS'(e);
      req_task_period   <= fpwt_pkg::TIME_BITS'(p);
      req_task_deadline <= fpwt_pkg::TIME_BITS'(d);
      req_new_set       <= fresh;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int set_len;
      int kind;
      int dl;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // bounds of the fields
      send_task(0, 65535, 65535, 1);
      send_task(65535, 65535, 65535, 0);
      // zero period and zero deadline
      send_task(0, 1, 1, 1);
      send_task(0, 0, 5, 0);
      send_task(0, 7, 0, 0);
      send_task(1, 7, 0, 0);
      send_task(2, 3, 9, 0);
      // overflow the store
      for (int i = 0; i < 35; i++)
         send_task(1, 65535, 60000, i == 0);

      for (int n = 0; n < 60; ) begin
         kind    = $urandom_range(0, 3);
         set_len = (kind == 0) ? $urandom_range(1, 4) : $urandom_range(1, 8);
         if (n > 45) calm = 1;
         for (int i = 0; i < set_len; i++, n++) begin
            if (kind == 0) begin
               // short periods: several scheduling points per task
               dl = $urandom_range(1, 100);
               send_task($urandom_range(0, dl / 3), $urandom_range(4, 64), dl, i == 0);
            end else begin
               dl = $urandom_range(1, 4096);
               if ($urandom_range(0, 4) == 0)
                  send_task($urandom_range(0, 65535), $urandom_range(4096, 65535), dl,
                            i == 0);
               else
                  send_task($urandom_range(0, dl / 4), $urandom_range(4096, 65535), dl,
                            i == 0);
            end
         end
      end
      req_valid <= 0;
      @(posedge clock);

      while (verdicts_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("fixed_priority_workload_test_top: match");
      else
         $display("fixed_priority_workload_test_top: mismatch");
      $finish;
   end
endmodule
